>>> rtl/core/rlh_pkg.sv
// ----------------------------------------------------------------------------
// rlh_pkg
// Shared constants, codes and types for the RGB / luma histogram unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rlh_pkg;

  localparam int COUNT_BITS_DEF = 24;
  localparam int OUT_BITS       = 24;
  localparam int BIN_BITS       = 8;
  localparam int BIN_COUNT      = 1 << BIN_BITS;
  localparam int NUM_MEMS       = 4;

  localparam logic [BIN_BITS-1:0] BIN_LAST = BIN_BITS'(BIN_COUNT - 1);

  // Store index of each histogram
  localparam int MEM_RED   = 0;
  localparam int MEM_GREEN = 1;
  localparam int MEM_BLUE  = 2;
  localparam int MEM_LUMA  = 3;

  // Request modes
  localparam logic [1:0] MODE_ADD   = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  typedef logic [BIN_BITS-1:0] bin_addr_t;

  typedef struct packed {
    logic      we;
    bin_addr_t waddr;
    bin_addr_t raddr;
  } mem_cmd_t;

  // Counts leave the block masked to the output width
  function automatic logic [OUT_BITS-1:0] to_out(input logic [31:0] v);
    return v[OUT_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/rgb_luma_histogram_unit.sv
// An add request steps through fetch, update, lookup and report; a read
// goes through lookup and report; a clear sweeps every bin, then looks up
// and reports. A new request is taken only while idle; busy is low while
// done shows, so the next request may be taken in that cycle.
// Reset (synchronous) runs a clearing pass over every bin with busy high.
// Results cannot be stalled: done strobes for exactly one cycle.
// ----------------------------------------------------------------------------
// rgb_luma_histogram_unit
// 256-bin red, green, blue and luma histograms with running peak counts.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_luma_histogram_unit #(
  parameter int COUNT_BITS = rlh_pkg::COUNT_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  mode,
  input  wire logic [7:0]  red,
  input  wire logic [7:0]  green,
  input  wire logic [7:0]  blue,
  input  wire logic [7:0]  bin_index,
  output logic             done,
  output logic [23:0]      red_count,
  output logic [23:0]      green_count,
  output logic [23:0]      blue_count,
  output logic [23:0]      luma_count,
  output logic [23:0]      max_rgb_count,
  output logic [23:0]      max_luma_count
);
  import rlh_pkg::*;

  logic                                  color_format;
  mem_cmd_t [NUM_MEMS-1:0]               cmd;
  logic [NUM_MEMS-1:0][COUNT_BITS-1:0]   wdata;
  logic [NUM_MEMS-1:0][COUNT_BITS-1:0]   rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      color_format <= 1'b1;
    end else if (cfg_wr_en) begin
      color_format <= cfg_wr_data;
    end
  end

  for (genvar m = 0; m < NUM_MEMS; m++) begin : g_mem
    rlh_bin_mem #(
      .WIDTH (COUNT_BITS)
    ) u_mem (
      .clk   (clk),
      .cmd   (cmd[m]),
      .wdata (wdata[m]),
      .rdata (rdata[m])
    );
  end

  rlh_ctrl #(
    .COUNT_BITS (COUNT_BITS)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .mode           (mode),
    .red            (red),
    .green          (green),
    .blue           (blue),
    .bin_index      (bin_index),
    .color_format   (color_format),
    .cmd            (cmd),
    .wdata          (wdata),
    .rdata          (rdata),
    .done           (done),
    .red_count      (red_count),
    .green_count    (green_count),
    .blue_count     (blue_count),
    .luma_count     (luma_count),
    .max_rgb_count  (max_rgb_count),
    .max_luma_count (max_luma_count)
  );

endmodule

`default_nettype wire

>>> rtl/core/rlh_bin_mem.sv
// ----------------------------------------------------------------------------
// rlh_bin_mem
// One histogram store: 256 bins, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rlh_bin_mem #(
  parameter int WIDTH = rlh_pkg::COUNT_BITS_DEF
) (
  input  wire logic             clk,
  input  wire rlh_pkg::mem_cmd_t cmd,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);
  import rlh_pkg::*;

  logic [WIDTH-1:0] mem [BIN_COUNT];

  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[cmd.waddr] <= wdata;
    end
    rdata <= mem[cmd.raddr];
  end

endmodule

`default_nettype wire

>>> rtl/core/rlh_ctrl.sv
// ----------------------------------------------------------------------------
// rlh_ctrl
// Sequencer and datapath: fetch, saturating increment, write back, peak
// tracking, clear sweep and result lookup.
// ----------------------------------------------------------------------------
`default_nettype none

module rlh_ctrl #(
  parameter int COUNT_BITS = rlh_pkg::COUNT_BITS_DEF
) (
  input  wire logic                                           clk,
  input  wire logic                                           rst,
  input  wire logic                                           start,
  output logic                                                busy,
  input  wire logic [1:0]                                     mode,
  input  wire logic [7:0]                                     red,
  input  wire logic [7:0]                                     green,
  input  wire logic [7:0]                                     blue,
  input  wire logic [7:0]                                     bin_index,
  input  wire logic                                           color_format,
  output rlh_pkg::mem_cmd_t [rlh_pkg::NUM_MEMS-1:0]           cmd,
  output logic [rlh_pkg::NUM_MEMS-1:0][COUNT_BITS-1:0]        wdata,
  input  wire logic [rlh_pkg::NUM_MEMS-1:0][COUNT_BITS-1:0]   rdata,
  output logic                                                done,
  output logic [rlh_pkg::OUT_BITS-1:0]                        red_count,
  output logic [rlh_pkg::OUT_BITS-1:0]                        green_count,
  output logic [rlh_pkg::OUT_BITS-1:0]                        blue_count,
  output logic [rlh_pkg::OUT_BITS-1:0]                        luma_count,
  output logic [rlh_pkg::OUT_BITS-1:0]                        max_rgb_count,
  output logic [rlh_pkg::OUT_BITS-1:0]                        max_luma_count
);
  import rlh_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_FETCH,
    S_UPDATE,
    S_LOOKUP,
    S_REPORT
  } state_t;

  typedef logic [COUNT_BITS-1:0] count_t;

  state_t                          state;
  bin_addr_t                       sweep_addr;
  logic                            clr_item;
  bin_addr_t [NUM_MEMS-1:0]        add_addr;
  bin_addr_t                       idx;
  logic                            fmt;
  count_t                          rgb_peak;
  count_t                          luma_peak;

  logic [12:0]                     y_sum;
  count_t [NUM_MEMS-1:0]           inc;
  count_t                          max_rg;
  count_t                          max_bp;
  count_t                          rgb_peak_next;
  count_t                          luma_peak_next;

  assign busy = (state != S_IDLE);

  // Luma bin: (11 r + 16 g + 5 b) / 32
  assign y_sum = 13'(red) * 13'd11 + 13'(green) * 13'd16 + 13'(blue) * 13'd5;

  always_comb begin
    for (int m = 0; m < NUM_MEMS; m++) begin
      inc[m] = (rdata[m] == '1) ? rdata[m] : rdata[m] + COUNT_BITS'(1);
    end
    max_rg         = (inc[MEM_RED] > inc[MEM_GREEN]) ? inc[MEM_RED] : inc[MEM_GREEN];
    max_bp         = (inc[MEM_BLUE] > rgb_peak) ? inc[MEM_BLUE] : rgb_peak;
    rgb_peak_next  = (max_rg > max_bp) ? max_rg : max_bp;
    luma_peak_next = (inc[MEM_LUMA] > luma_peak) ? inc[MEM_LUMA] : luma_peak;
  end

  always_comb begin
    for (int m = 0; m < NUM_MEMS; m++) begin
      cmd[m].waddr = (state == S_CLEAR) ? sweep_addr : add_addr[m];
      cmd[m].raddr = (state == S_FETCH) ? add_addr[m] : idx;
      wdata[m]     = (state == S_CLEAR) ? '0 : inc[m];
      if (state == S_CLEAR) begin
        cmd[m].we = 1'b1;
      end else if (state == S_UPDATE) begin
        cmd[m].we = fmt ? (m != MEM_LUMA) : (m == MEM_LUMA);
      end else begin
        cmd[m].we = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      sweep_addr <= '0;
      clr_item   <= 1'b0;
      rgb_peak   <= COUNT_BITS'(1);
      luma_peak  <= COUNT_BITS'(1);
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            add_addr[MEM_RED]   <= red;
            add_addr[MEM_GREEN] <= green;
            add_addr[MEM_BLUE]  <= blue;
            add_addr[MEM_LUMA]  <= y_sum[12:5];
            idx                 <= bin_index;
            fmt                 <= color_format;
            priority if (mode == MODE_ADD) begin
              state <= S_FETCH;
            end else if (mode == MODE_CLEAR) begin
              state      <= S_CLEAR;
              sweep_addr <= '0;
              clr_item   <= 1'b1;
              rgb_peak   <= COUNT_BITS'(1);
              luma_peak  <= COUNT_BITS'(1);
            end else begin
              // read and the unused code both just look up the bin
              state <= S_LOOKUP;
            end
          end
        end
        S_CLEAR: begin
          sweep_addr <= sweep_addr + 1'b1;
          if (sweep_addr == BIN_LAST) begin
            state    <= clr_item ? S_LOOKUP : S_IDLE;
            clr_item <= 1'b0;
          end
        end
        S_FETCH: begin
          state <= S_UPDATE;
        end
        S_UPDATE: begin
          if (fmt) begin
            rgb_peak <= rgb_peak_next;
          end else begin
            luma_peak <= luma_peak_next;
          end
          state <= S_LOOKUP;
        end
        S_LOOKUP: begin
          state <= S_REPORT;
        end
        S_REPORT: begin
          red_count      <= to_out(32'(rdata[MEM_RED]));
          green_count    <= to_out(32'(rdata[MEM_GREEN]));
          blue_count     <= to_out(32'(rdata[MEM_BLUE]));
          luma_count     <= to_out(32'(rdata[MEM_LUMA]));
          max_rgb_count  <= to_out(32'(rgb_peak));
          max_luma_count <= to_out(32'(luma_peak));
          done           <= 1'b1;
          state          <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/rlh_checker.sv
// ----------------------------------------------------------------------------
// rlh_checker
// Port-level checks on request, busy and done sequencing.
// ----------------------------------------------------------------------------
`default_nettype none

module rlh_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic done
);

  // Taken request occupies the unit in the following cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted but unit not busy next cycle");

  // Done lasts one cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held longer than one cycle");

  // Done only follows work in progress
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(done) |-> $past(busy))
    else $error("done without a request in progress");

  // Clearing pass runs after reset
  a_reset_clear: assert property (@(posedge clk)
    $fell(rst) |-> busy)
    else $error("unit not busy clearing after reset");

endmodule

bind rgb_luma_histogram_unit rlh_checker u_rlh_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);

`default_nettype wire
